// ----- src/gkh_pkg.sv -----
// Shared constants, codes and types of the gapped k-mer hash generator.
package gkh_pkg;

    localparam int CODE_W         = 5;
    localparam int HASH_W         = 20;
    localparam int OFF_W          = 4;
    localparam int RANK_W         = 2;
    localparam int RESIDUE_W      = 7;
    localparam int WIN_W          = 4;
    localparam int KLEN_W         = 3;
    localparam int CFG_DATA_W     = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int POS_W          = 4;
    localparam int NUM_LANES      = 3;
    localparam int DEF_MAX_WINDOW = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KMER   = 1'b1;

    localparam logic [WIN_W-1:0]     WIN_RESET   = 4'd8;
    localparam logic [KLEN_W-1:0]    KLEN_RESET  = 3'd3;
    localparam logic [KLEN_W-1:0]    KLEN_MIN    = 3'd2;
    localparam logic [KLEN_W-1:0]    KLEN_MAX    = 3'd4;
    localparam logic [WIN_W-1:0]     WIN_MIN     = 4'd2;
    localparam logic [RESIDUE_W-1:0] LETTER_BASE = 7'd65;
    localparam logic [POS_W-1:0]     POS_SAT     = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    // Current offset combination as seen by the hash path and the controller.
    typedef struct packed {
        logic              more;
        logic [RANK_W-1:0] rank;
        logic [OFF_W-1:0]  last_off;
        logic [OFF_W-1:0]  off0;
        logic [OFF_W-1:0]  off1;
    } t_seq_stat;

    typedef struct packed {
        logic start;
        logic step;
    } t_seq_ctl;

endpackage

// ----- src/gkh_mask_seq.sv -----
// Offset mask sequencer: steps through the offset combinations in lexicographic order.
module gkh_mask_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gkh_pkg::t_seq_ctl         i_ctl,
    input  logic [gkh_pkg::WIN_W-1:0] i_win,
    input  logic [gkh_pkg::RANK_W-1:0] i_rank,
    output gkh_pkg::t_seq_stat        o_stat
);
    import gkh_pkg::*;

    logic [OFF_W-1:0]  r_off [NUM_LANES];
    logic [OFF_W-1:0]  n_off [NUM_LANES];
    logic [RANK_W-1:0] r_rank;
    logic [WIN_W-1:0]  r_win;
    logic              r_more;
    logic              found;

    // The highest lane still below its ceiling advances, and every lane after
    // it restarts right behind it.
    always_comb begin
        logic [1:0] jsel;
        logic [OFF_W:0] lhs;
        logic [OFF_W:0] rhs;
        found = 1'b0;
        jsel  = 2'd0;
        for (int j = 0; j < NUM_LANES; j++) begin
            lhs = {1'b0, r_off[j]} + {{(OFF_W+1-RANK_W){1'b0}}, r_rank};
            rhs = {1'b0, r_win} + (OFF_W+1)'(j);
            if ((2'(j) < r_rank) && (lhs < rhs)) begin
                found = 1'b1;
                jsel  = 2'(j);
            end
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            if (2'(i) < jsel) begin
                n_off[i] = r_off[i];
            end else begin
                n_off[i] = r_off[jsel] + OFF_W'(1) + OFF_W'(i) - {{(OFF_W-2){1'b0}}, jsel};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_more <= 1'b0;
        end else if (i_ctl.start) begin
            r_more <= ({{(WIN_W-RANK_W){1'b0}}, i_rank} < i_win);
        end else if (i_ctl.step && !found) begin
            r_more <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rank <= i_rank;
            r_win  <= i_win;
            for (int i = 0; i < NUM_LANES; i++) begin
                r_off[i] <= OFF_W'(i + 1);
            end
        end else if (i_ctl.step && found) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_off[i] <= n_off[i];
            end
        end
    end

    always_comb begin
        o_stat.more = r_more;
        o_stat.rank = r_rank;
        o_stat.off0 = r_off[0];
        o_stat.off1 = r_off[1];
        case (r_rank)
            2'd1:    o_stat.last_off = r_off[0];
            2'd2:    o_stat.last_off = r_off[1];
            default: o_stat.last_off = r_off[2];
        endcase
    end

endmodule

// ----- src/gkh_hist.sv -----
// Letter history shift line and packed hash assembly for the current mask.
module gkh_hist #(
    parameter int P_MAX_WINDOW = gkh_pkg::DEF_MAX_WINDOW
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [gkh_pkg::CODE_W-1:0] i_code,
    input  logic                       i_commit,
    input  gkh_pkg::t_seq_stat         i_stat,
    output logic [gkh_pkg::HASH_W-1:0] o_hash
);
    import gkh_pkg::*;

    localparam int HIST_DEPTH = P_MAX_WINDOW - 1;
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    logic [CODE_W-1:0] r_cur;
    logic [CODE_W-1:0] r_hist [HIST_DEPTH];

    function automatic logic [CODE_W-1:0] code_back(input logic [OFF_W-1:0] t);
        logic [OFF_W-1:0] tm1;
        tm1 = t - OFF_W'(1);
        if (t == '0) begin
            code_back = r_cur;
        end else begin
            code_back = r_hist[tm1[IDX_W-1:0]];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cur <= i_code;
        end
        if (i_commit) begin
            r_hist[0] <= r_cur;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_comb begin
        logic [CODE_W-1:0] c_first;
        logic [CODE_W-1:0] c_mid0;
        logic [CODE_W-1:0] c_mid1;
        c_first = code_back(i_stat.last_off);
        c_mid0  = code_back(i_stat.last_off - i_stat.off0);
        c_mid1  = code_back(i_stat.last_off - i_stat.off1);
        case (i_stat.rank)
            2'd1:    o_hash = {{(2*CODE_W){1'b0}}, c_first, r_cur};
            2'd2:    o_hash = {{CODE_W{1'b0}}, c_first, c_mid0, r_cur};
            default: o_hash = {c_first, c_mid0, c_mid1, r_cur};
        endcase
    end

endmodule

// ----- src/gapped_kmer_hash_generator.sv -----
// Top level of the gapped k-mer hash generator: control, configuration and output stage.
//
// The block takes one amino-acid letter per input beat and returns, for every gapped
// k-mer that ends on that letter, one 20-bit hash with five bits per letter (letter
// minus 'A'), first letter most significant; the last hash of a letter carries
// last_of_run. A k-mer is a first letter plus k-1 later offsets taken from 1..w-1,
// walked in lexicographic order, and a mask fires only when its largest offset fits
// within the letters already seen in the current sequence. After a letter is
// accepted the block is busy while the mask sequencer visits each offset combination,
// one per cycle while the output side does not stall it, then sees that the last
// combination is done, and then hands over the final hash. A letter that fires no
// mask still walks every combination. One finished hash is held back so that
// last_of_run can be set on it, and one more sits in the output register, so the
// sequencer stalls only if a mask fires while both are full and the output waits.
// Window width and k-mer length are clamped to 2..P_MAX_WINDOW and 2..4; the user
// must write them only while the block is idle; the block does not enforce this.
module gapped_kmer_hash_generator #(
    parameter int P_MAX_WINDOW = gkh_pkg::DEF_MAX_WINDOW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gkh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gkh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gkh_pkg::RESIDUE_W-1:0] i_residue,
    input  logic                          i_seq_start,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gkh_pkg::HASH_W-1:0]    o_kmer_hash,
    output logic                          o_last_of_run
);
    import gkh_pkg::*;

    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(P_MAX_WINDOW);

    t_state              r_state, n_state;
    logic [WIN_W-1:0]    r_win_cfg;
    logic [KLEN_W-1:0]   r_klen_cfg;
    logic [POS_W-1:0]    r_pos_cnt;
    logic [POS_W-1:0]    r_pos_snap;
    logic                r_out_valid;
    logic [HASH_W-1:0]   r_out_hash;
    logic                r_out_last;
    logic                r_pend_valid;
    logic [HASH_W-1:0]   r_pend_hash;

    t_seq_ctl            seq_ctl;
    t_seq_stat           seq_stat;
    logic [HASH_W-1:0]   mask_hash;
    logic [WIN_W-1:0]    win_eff;
    logic [KLEN_W-1:0]   klen_eff;
    logic [RANK_W-1:0]   rank_eff;
    logic [RESIDUE_W-1:0] letter_diff;
    logic [POS_W-1:0]    pos_start;
    logic                in_fire;
    logic                slot_free;
    logic                mask_fire;
    logic                stall;
    logic                push_mid;
    logic                push_last;
    logic                take_mask;
    logic                commit;

    // Register writes; only legal while idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg  <= WIN_RESET;
            r_klen_cfg <= KLEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW: r_win_cfg  <= i_cfg_data[WIN_W-1:0];
                REG_KMER:   r_klen_cfg <= i_cfg_data[KLEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        win_eff = r_win_cfg;
        if (r_win_cfg < WIN_MIN) win_eff = WIN_MIN;
        if (r_win_cfg > WIN_MAX) win_eff = WIN_MAX;
        klen_eff = r_klen_cfg;
        if (r_klen_cfg < KLEN_MIN) klen_eff = KLEN_MIN;
        if (r_klen_cfg > KLEN_MAX) klen_eff = KLEN_MAX;
        rank_eff = RANK_W'(klen_eff - KLEN_W'(1));
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign letter_diff = i_residue - LETTER_BASE;
    assign pos_start   = i_seq_start ? '0 : r_pos_cnt;

    assign slot_free = !r_out_valid || i_out_ready;
    assign mask_fire = (r_state == ST_RUN) && seq_stat.more
                       && (POS_W'(seq_stat.last_off) <= r_pos_snap);
    // A second firing mask can only move on if the held hash has somewhere to go.
    assign stall     = mask_fire && r_pend_valid && !slot_free;
    assign push_mid  = mask_fire && r_pend_valid && !stall;
    assign take_mask = mask_fire && !stall;

    always_comb begin
        n_state       = r_state;
        seq_ctl.start = 1'b0;
        seq_ctl.step  = 1'b0;
        push_last     = 1'b0;
        commit        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    seq_ctl.start = 1'b1;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!seq_stat.more) begin
                    n_state = ST_FLUSH;
                end else if (!stall) begin
                    seq_ctl.step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end else if (slot_free) begin
                    push_last = 1'b1;
                    commit    = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Position within the sequence, saturating.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_cnt <= '0;
        end else if (in_fire) begin
            r_pos_cnt <= (pos_start == POS_SAT) ? POS_SAT : pos_start + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pos_snap <= pos_start;
        end
    end

    // Held-back hash and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take_mask) begin
                r_pend_valid <= 1'b1;
            end else if (push_last) begin
                r_pend_valid <= 1'b0;
            end
            if (push_mid || push_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_mask) begin
            r_pend_hash <= mask_hash;
        end
        if (push_mid || push_last) begin
            r_out_hash <= r_pend_hash;
            r_out_last <= push_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kmer_hash   = r_out_hash;
    assign o_last_of_run = r_out_last;

    gkh_mask_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_ctl),
        .i_win   (win_eff),
        .i_rank  (rank_eff),
        .o_stat  (seq_stat)
    );

    gkh_hist #(
        .P_MAX_WINDOW (P_MAX_WINDOW)
    ) u_hist (
        .i_clk    (i_clk),
        .i_load   (in_fire),
        .i_code   (letter_diff[CODE_W-1:0]),
        .i_commit (commit),
        .i_stat   (seq_stat),
        .o_hash   (mask_hash)
    );

endmodule

// ----- src/gkh_checker.sv -----
// Port-level checks of the gapped k-mer hash generator, bound to the top level.
module gkh_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [gkh_pkg::HASH_W-1:0]    o_kmer_hash,
    input logic                          o_last_of_run
);

    // Leaving reset the block is idle with nothing to deliver.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

    // After an accepted letter the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accepting a letter");

    // A stalled result beat holds its value and its run flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_kmer_hash) && $stable(o_last_of_run)))
        else $error("stalled result beat changed");

endmodule

bind gapped_kmer_hash_generator gkh_checker u_gkh_checker (.*);

// ----- sim/tb_gapped_kmer_hash_generator.sv -----
// Self-checking testbench for the gapped k-mer hash generator with random flow control.
module tb_gapped_kmer_hash_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import gkh_pkg::*;

    // One letter beat on the input side and one hash beat on the output side.
    typedef struct packed {
        logic [RESIDUE_W-1:0] residue;
        logic                 seq_start;
    } t_letter_beat;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              last;
    } t_hash_beat;

    // Cycles to let pass once nothing is expected any more. The slowest letter walks
    // all C(8,3) = 56 offset combinations even when it fires no mask.
    localparam int DRAIN_CYCLES = 70;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = REG_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [RESIDUE_W-1:0]  residue    = LETTER_BASE;
    logic                  seq_start  = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [HASH_W-1:0]     kmer_hash;
    logic                  last_of_run;

    // Letters still to be offered, and hashes predicted but not yet seen.
    t_letter_beat letter_queue [$];
    t_hash_beat   hash_expect  [$];

    // Predictor state: a private copy of the registers, the letter history and the
    // position inside the current sequence.
    logic [WIN_W-1:0]  cfg_window = WIN_RESET;
    logic [KLEN_W-1:0] cfg_klen   = KLEN_RESET;
    logic [CODE_W-1:0] prior_codes [8];
    logic [POS_W-1:0]  seq_pos    = '0;

    int mismatch_count = 0;
    int send_gap       = 0;
    int send_calm      = 0;
    int recv_gap       = 0;
    int recv_calm      = 0;

    gapped_kmer_hash_generator u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_residue     (residue),
        .i_seq_start   (seq_start),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_kmer_hash   (kmer_hash),
        .o_last_of_run (last_of_run)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles before the next beat on one side. Most draws are uniform over 0..9,
    // but now and then a calm stretch starts in which that side never idles.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Code of the letter t places back in the sequence; t = 0 is the letter just taken.
    function automatic logic [CODE_W-1:0] code_at(input logic [CODE_W-1:0] cur, input int t);
        return (t == 0) ? cur : prior_codes[t-1];
    endfunction

    // Works out every hash that one letter fires and queues them in order. Offsets
    // are walked as combinations of k-1 values from 1..w-1 in lexicographic order;
    // a combination fires when its largest offset reaches no further back than the
    // letters already seen in this sequence.
    function automatic void predict_hashes(input logic [RESIDUE_W-1:0] letter,
                                           input logic                 starts);
        int                   w;
        int                   k;
        int                   r;
        int                   m;
        int                   j;
        int                   off [3];
        bit                   more;
        logic [RESIDUE_W-1:0] diff;
        logic [CODE_W-1:0]    cur;
        logic [31:0]          h;
        t_hash_beat           fired [$];
        t_hash_beat           beat;

        // Out-of-range settings are clamped, as the block does.
        w = int'(cfg_window);
        k = int'(cfg_klen);
        if (w < int'(WIN_MIN))      w = int'(WIN_MIN);
        if (w > DEF_MAX_WINDOW)     w = DEF_MAX_WINDOW;
        if (k < int'(KLEN_MIN))     k = int'(KLEN_MIN);
        if (k > int'(KLEN_MAX))     k = int'(KLEN_MAX);
        r = k - 1;

        // A sequence start clears the position before the letter is handled.
        if (starts) seq_pos = '0;
        diff = letter - LETTER_BASE;
        cur  = diff[CODE_W-1:0];

        for (int i = 0; i < r; i++) off[i] = i + 1;
        more = (off[r-1] < w);
        while (more) begin
            m = off[r-1];
            if (m <= int'(seq_pos)) begin
                h = 32'(code_at(cur, m));
                for (int i = 0; i < r; i++) h = (h << CODE_W) | 32'(code_at(cur, m - off[i]));
                beat.hash = h[HASH_W-1:0];
                beat.last = 1'b0;
                fired.push_back(beat);
            end
            j = r - 1;
            while (j >= 0 && off[j] >= w - r + j) j--;
            if (j < 0) begin
                more = 1'b0;
            end else begin
                off[j]++;
                for (int i = j + 1; i < r; i++) off[i] = off[i-1] + 1;
            end
        end

        if (fired.size() != 0) fired[fired.size()-1].last = 1'b1;
        foreach (fired[i]) hash_expect.push_back(fired[i]);

        for (int i = 7; i > 0; i--) prior_codes[i] = prior_codes[i-1];
        prior_codes[0] = cur;
        if (seq_pos != POS_SAT) seq_pos = seq_pos + 1'b1;
    endfunction

    task automatic log_fault(input string what, input t_hash_beat want, input t_hash_beat got);
        if (mismatch_count < 10) begin
            $display("%0t: %s: expected hash %05h last %0b, got hash %05h last %0b",
                     $realtime, what, want.hash, want.last, got.hash, got.last);
        end
        mismatch_count++;
    endtask

    // Letter driver. The item in flight is held until in_ready takes it; after each
    // accepted beat the predictor runs and the next letter follows its drawn gap.
    always @(posedge clk) begin : letter_driver
        t_letter_beat nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!(in_valid && !in_ready)) begin
            if (in_valid) predict_hashes(residue, seq_start);
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (letter_queue.size() != 0) begin
                nxt = letter_queue.pop_front();
                residue   <= nxt.residue;
                seq_start <= nxt.seq_start;
                in_valid  <= 1'b1;
                send_gap  <= draw_wait(send_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Hash monitor. Every accepted beat is compared with the oldest prediction; the
    // ready line then may drop for a drawn number of cycles, whether or not more is coming.
    always @(posedge clk) begin : hash_monitor
        t_hash_beat want;
        t_hash_beat got;
        int         stall;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end else if (out_valid && out_ready) begin
            got.hash = kmer_hash;
            got.last = last_of_run;
            if (hash_expect.size() == 0) begin
                want = '0;
                log_fault("hash beat with nothing expected", want, got);
            end else begin
                want = hash_expect.pop_front();
                if (got.hash !== want.hash || got.last !== want.last)
                    log_fault("hash mismatch", want, got);
            end
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                out_ready <= 1'b0;
                recv_gap  <= stall - 1;
            end
        end else if (!out_ready) begin
            if (recv_gap == 0) out_ready <= 1'b1;
            else               recv_gap  <= recv_gap - 1;
        end
    end

    // Register writes happen only while the block is idle, so the predictor copy is
    // updated at the same edge as the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW) cfg_window = data;
        else                   cfg_klen   = data[KLEN_W-1:0];
    endtask

    // Waits until every letter is taken and every hash has come, then lets the block
    // finish a letter that fires nothing.
    task automatic settle();
        @(negedge clk);
        while (letter_queue.size() != 0 || in_valid || hash_expect.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_letter(input logic [RESIDUE_W-1:0] letter, input logic starts);
        t_letter_beat beat;
        beat.residue   = letter;
        beat.seq_start = starts;
        letter_queue.push_back(beat);
    endtask

    // Random letters for one setting: mostly well-formed sequences of 1..20 letters,
    // long enough at times to saturate the position count, with some stray letters
    // outside A..Z and some lone beats that may or may not start a sequence. The first
    // letter of a phase may carry on the sequence from before the register change.
    task automatic queue_random_letters(input int count);
        int  len;
        bit  first;
        logic [RESIDUE_W-1:0] letter;
        first = 1'b1;
        while (count > 0) begin
            if ($urandom_range(0, 5) == 0) begin
                push_letter(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                count--;
            end else begin
                len = $urandom_range(1, 20);
                if (len > count) len = count;
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 11) == 0) letter = 7'($urandom_range(0, 127));
                    else                            letter = 7'($urandom_range(65, 90));
                    push_letter(letter, (i == 0) ? (first ? 1'($urandom_range(0, 1)) : 1'b1)
                                                 : 1'b0);
                end
                count -= len;
            end
            first = 1'b0;
        end
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] sweep_win  [10];
        logic [CFG_DATA_W-1:0] sweep_klen [10];
        // Settings visited by the random part: both corners, clamped values on each
        // side, a setting where no mask fits (k-1 above w-1), and a k-mer length whose
        // top bit lies outside the register.
        sweep_win  = '{4'd2, 4'd9, 4'd15, 4'd0, 4'd3, 4'd5, 4'd1, 4'd12, 4'd8, 4'd7};
        sweep_klen = '{4'd2, 4'd4, 4'd7, 4'd0, 4'd4, 4'd3, 4'd1, 4'd6, 4'd10, 4'd15};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting (w = 8, k = 3). The very first letter has no start flag, both
        // ends of the alphabet appear, codes below 'A' and at the top of the field wrap,
        // and a start in the middle clears the position.
        @(negedge clk);
        push_letter(LETTER_BASE, 1'b0);
        push_letter(7'd90, 1'b0);
        push_letter(7'h00, 1'b0);
        push_letter(7'h7F, 1'b0);
        push_letter(7'd90, 1'b1);
        push_letter(LETTER_BASE, 1'b0);
        push_letter(7'd90, 1'b0);
        settle();

        // Widest window and longest k-mer: one sequence of 17 letters fires all 56 masks
        // once the history is full and runs the position count into saturation.
        write_reg(REG_WINDOW, 4'd9);
        write_reg(REG_KMER, 4'd4);
        @(negedge clk);
        for (int i = 0; i < 17; i++)
            push_letter((i % 2 == 0) ? 7'(65 + i) : 7'(90 - i), i == 0);
        settle();

        for (int p = 0; p < 12; p++) begin
            if (p < 10) begin
                write_reg(REG_WINDOW, sweep_win[p]);
                write_reg(REG_KMER, sweep_klen[p]);
            end else begin
                write_reg(REG_WINDOW, 4'($urandom_range(0, 15)));
                write_reg(REG_KMER, 4'($urandom_range(0, 15)));
            end
            @(negedge clk);
            queue_random_letters(16);
            settle();
        end

        if (mismatch_count == 0 && hash_expect.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin : watchdog
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
